// ===== hw/rtl/sb2ad_pkg.sv =====
// Package for the signed binary to ASCII decimal converter.
// Character codes, field widths and the BCD digit type. No dependencies.
`default_nettype none

package sb2ad_pkg;

    localparam int VALUE_W = 64;
    localparam int CHAR_W  = 6;
    localparam int TDATA_W = 8;
    localparam int DIGIT_W = 4;

    typedef logic [DIGIT_W-1:0] t_digit;
    typedef logic [CHAR_W-1:0]  t_char;

    localparam t_char CH_ZERO  = 6'd48;
    localparam t_char CH_MINUS = 6'd45;

    // Double-dabble correction: a digit of five or more gets three added
    // before the shift.
    function automatic t_digit dabble_adjust(input t_digit d);
        t_digit r;
        r = d;
        if (d >= 4'd5) begin
            r = d + 4'd3;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/signed_binary_to_ascii_decimal.sv =====
// Signed 64-bit binary to ASCII decimal text, one character per output item.
// Depends on sb2ad_pkg.
//
// Usage:
//   Input stream: one signed 64-bit value per item on s_axis_tdata.
//   Output stream: one ASCII character per item on m_axis_tdata[5:0], the
//   minus sign first for a negative value, then the digits most significant
//   first; m_axis_tlast marks the final character. Zero is written as '0'.
//   With MAX_DIGITS below 19 only the least significant digits are written.
// Timing:
//   s_axis_tready is high only while idle. One shared shift-and-correct step
//   runs for each input bit, then the leading-zero scan drops leading zeros,
//   then the sign slot, then one output item per digit; the next value is
//   not taken until the final character is loaded. The minus sign is loaded
//   in the sign slot after the scan; the first digit of a positive value is
//   loaded after that slot.
// Stalls and reset:
//   A stall on m_axis_tready holds the sign and digit states until the register frees; the
//   next value is taken in the cycle after the final character is loaded. Reset
//   (synchronous, active low) empties the output register and idles the block.
`default_nettype none

module signed_binary_to_ascii_decimal
    import sb2ad_pkg::*;
#(
    parameter int MAX_DIGITS = 19
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  s_axis_tvalid,
    output logic                 s_axis_tready,
    input  wire  [VALUE_W-1:0]   s_axis_tdata,   // [63:0] value (signed)
    output logic                 m_axis_tvalid,
    input  wire                  m_axis_tready,
    output logic [TDATA_W-1:0]   m_axis_tdata,   // [5:0] char_code, [7:6] zero
    output logic                 m_axis_tlast    // last
);

    localparam int IDX_W = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
    localparam int CNT_W = $clog2(VALUE_W);
    localparam logic [IDX_W-1:0] IDX_TOP  = IDX_W'(MAX_DIGITS - 1);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(VALUE_W - 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CONV,
        ST_SKIP,
        ST_SIGN,
        ST_EMIT
    } t_state;

    t_state             r_state;
    logic [VALUE_W-1:0] r_mag;
    logic               r_neg;
    logic               r_ovf;
    logic [CNT_W-1:0]   r_cnt;
    logic [IDX_W-1:0]   r_idx;
    t_digit             r_bcd [MAX_DIGITS];
    logic               r_m_valid;
    t_char              r_char;
    logic               r_last;

    t_digit             n_bcd [MAX_DIGITS];
    t_digit             w_adj [MAX_DIGITS];
    logic               w_carry_out;
    logic               w_slot;
    logic               w_load;
    t_digit             w_cur;
    logic [VALUE_W-1:0] w_in_mag;

    // One double-dabble step across all digit lanes.
    always_comb begin
        for (int i = 0; i < MAX_DIGITS; i++) begin
            w_adj[i] = dabble_adjust(r_bcd[i]);
        end
        n_bcd[0] = {w_adj[0][DIGIT_W-2:0], r_mag[VALUE_W-1]};
        for (int i = 1; i < MAX_DIGITS; i++) begin
            n_bcd[i] = {w_adj[i][DIGIT_W-2:0], w_adj[i-1][DIGIT_W-1]};
        end
        w_carry_out = w_adj[MAX_DIGITS-1][DIGIT_W-1];
    end

    assign w_in_mag      = s_axis_tdata[VALUE_W-1] ? (~s_axis_tdata + 64'd1) : s_axis_tdata;
    assign w_slot        = !r_m_valid || m_axis_tready;
    assign w_load        = w_slot && ((r_state == ST_SIGN && r_neg) || r_state == ST_EMIT);
    assign w_cur         = r_bcd[r_idx];
    assign s_axis_tready = (r_state == ST_IDLE);
    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = {{(TDATA_W-CHAR_W){1'b0}}, r_char};
    assign m_axis_tlast  = r_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_m_valid <= 1'b0;
            r_cnt     <= '0;
            r_idx     <= '0;
        end else begin
            if (w_load) begin
                r_m_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_m_valid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (s_axis_tvalid) begin
                        r_mag <= w_in_mag;
                        r_neg <= s_axis_tdata[VALUE_W-1];
                        r_ovf <= 1'b0;
                        r_cnt <= '0;
                        for (int i = 0; i < MAX_DIGITS; i++) begin
                            r_bcd[i] <= '0;
                        end
                        r_state <= ST_CONV;
                    end
                end
                ST_CONV: begin
                    r_bcd <= n_bcd;
                    r_mag <= {r_mag[VALUE_W-2:0], 1'b0};
                    r_ovf <= r_ovf | w_carry_out;
                    r_cnt <= r_cnt + CNT_W'(1);
                    if (r_cnt == CNT_LAST) begin
                        r_idx   <= IDX_TOP;
                        r_state <= ST_SKIP;
                    end
                end
                ST_SKIP: begin
                    // leading zeros are dropped unless digits were cut off
                    if (!r_ovf && w_cur == '0 && r_idx != '0) begin
                        r_idx <= r_idx - IDX_W'(1);
                    end else begin
                        r_state <= ST_SIGN;
                    end
                end
                ST_SIGN: begin
                    if (!r_neg) begin
                        r_state <= ST_EMIT;
                    end else if (w_slot) begin
                        r_char    <= CH_MINUS;
                        r_last    <= 1'b0;
                        r_state   <= ST_EMIT;
                    end
                end
                ST_EMIT: begin
                    if (w_slot) begin
                        r_char    <= CH_ZERO + t_char'(w_cur);
                        r_last    <= (r_idx == '0);
                        if (r_idx == '0) begin
                            r_state <= ST_IDLE;
                        end else begin
                            r_idx <= r_idx - IDX_W'(1);
                        end
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    a_conv_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CONV && r_cnt == CNT_LAST) |=> (r_state == ST_SKIP))
        else $error("conversion did not end after the final bit");

    a_emit_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EMIT && !w_slot) |=> ($stable(r_idx) && r_state == ST_EMIT))
        else $error("digit pointer moved while output was stalled");

    a_minus_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_m_valid && r_char == CH_MINUS) |-> !r_last)
        else $error("minus sign flagged as final character");

    a_skip_stops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SKIP && w_cur != '0) |=> (r_state == ST_SIGN))
        else $error("scan passed a nonzero leading digit");

endmodule

`default_nettype wire
